// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, muted while reset is low
`define SAU_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("sau check failed");

// same check, also evaluated during reset
`define SAU_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("sau check failed during reset");

`endif

// ===== rtl/sau_pkg.sv =====
package sau_pkg;

	localparam int COORD_W = 32;
	localparam int NORM_W = 16;
	localparam int ANGLE_W = 16;

	localparam int CORDIC_STEPS = 18;
	localparam int ATAN_W = 24;

	localparam logic [ATAN_W-1:0] ATAN_Q24 [0:CORDIC_STEPS-1] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
		24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
		24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024,
		24'd512, 24'd256, 24'd128
	};

	localparam logic [ANGLE_W-1:0] RAD_HALF_PI_Q15 = 16'd51472;
	localparam logic [ANGLE_W-1:0] DEG_NINETY_Q8 = 16'd23040;
	localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754936;

	// register indexes on the config port
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;
	localparam logic [1:0] REG_DEG_MODE = 2'd3;

	typedef struct packed {
		logic deg;
		logic zero;
	} sau_flags_t;

endpackage

// ===== rtl/sau_isqrt.sv =====
module sau_isqrt #(
	parameter int IN_W = 62,
	parameter int SIDE_W = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int RW = IN_W / 2;

	logic [RW+1:0]     rem_a  [0:RW];
	logic [RW-1:0]     root_a [0:RW];
	logic [IN_W-1:0]   v_a    [0:RW];
	logic [SIDE_W-1:0] side_a [0:RW];
	logic              vld_a  [0:RW];

	assign rem_a[0] = '0;
	assign root_a[0] = '0;
	assign v_a[0] = radicand;
	assign side_a[0] = side_in;
	assign vld_a[0] = in_valid;

	// one root bit per stage, two radicand bits consumed each step
	for (genvar i = 0; i < RW; i++) begin : g_step
		localparam int J = RW - 1 - i;
		logic [RW+3:0] remsh;
		logic [RW+3:0] trial;
		logic [RW+3:0] diff;

		assign remsh = {rem_a[i], v_a[i][2*J+1 -: 2]};
		assign trial = {2'b00, root_a[i], 2'b01};
		assign diff = remsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[i+1] <= 1'b0;
			end else if (en) begin
				vld_a[i+1] <= vld_a[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_a[i+1] <= v_a[i];
				side_a[i+1] <= side_a[i];
				if (remsh >= trial) begin
					rem_a[i+1] <= diff[RW+1:0];
					root_a[i+1] <= {root_a[i][RW-2:0], 1'b1};
				end else begin
					rem_a[i+1] <= remsh[RW+1:0];
					root_a[i+1] <= {root_a[i][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_a[RW];
	assign root = root_a[RW];
	assign side_out = side_a[RW];

endmodule

// ===== rtl/sau_div.sv =====
module sau_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 31,
	parameter int Q_W = 31,
	parameter int SIDE_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_W-1:0]    quot,
	output logic [SIDE_W-1:0] side_out
);

	logic [NUM_W-1:0]  rem_a  [0:Q_W];
	logic [DEN_W-1:0]  den_a  [0:Q_W];
	logic [Q_W-1:0]    q_a    [0:Q_W];
	logic [SIDE_W-1:0] side_a [0:Q_W];
	logic              vld_a  [0:Q_W];

	assign rem_a[0] = num;
	assign den_a[0] = den;
	assign q_a[0] = '0;
	assign side_a[0] = side_in;
	assign vld_a[0] = in_valid;

	// restoring division, quotient msb first
	for (genvar i = 0; i < Q_W; i++) begin : g_step
		localparam int B = Q_W - 1 - i;
		logic [NUM_W-1:0] dsh;

		assign dsh = NUM_W'(den_a[i]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[i+1] <= 1'b0;
			end else if (en) begin
				vld_a[i+1] <= vld_a[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_a[i+1] <= den_a[i];
				side_a[i+1] <= side_a[i];
				if (rem_a[i] >= dsh) begin
					rem_a[i+1] <= rem_a[i] - dsh;
					q_a[i+1] <= {q_a[i][Q_W-2:0], 1'b1};
				end else begin
					rem_a[i+1] <= rem_a[i];
					q_a[i+1] <= {q_a[i][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_a[Q_W];
	assign quot = q_a[Q_W];
	assign side_out = side_a[Q_W];

endmodule

// ===== rtl/sau_cordic.sv =====
module sau_cordic #(
	parameter int XY_W = 34,
	parameter int Z_W = 28,
	parameter int SIDE_W = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	output logic signed [Z_W-1:0]  z_out,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int N = sau_pkg::CORDIC_STEPS;

	logic signed [XY_W-1:0] x_a    [0:N];
	logic signed [XY_W-1:0] y_a    [0:N];
	logic signed [Z_W-1:0]  z_a    [0:N];
	logic [SIDE_W-1:0]      side_a [0:N];
	logic                   vld_a  [0:N];

	assign x_a[0] = x_in;
	assign y_a[0] = y_in;
	assign z_a[0] = '0;
	assign side_a[0] = side_in;
	assign vld_a[0] = in_valid;

	// vectoring mode, drives y toward zero
	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		logic signed [Z_W-1:0]  at;

		assign xs = x_a[i] >>> i;
		assign ys = y_a[i] >>> i;
		assign at = signed'(Z_W'(sau_pkg::ATAN_Q24[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[i+1] <= 1'b0;
			end else if (en) begin
				vld_a[i+1] <= vld_a[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_a[i+1] <= side_a[i];
				if (y_a[i] > 0) begin
					x_a[i+1] <= x_a[i] + ys;
					y_a[i+1] <= y_a[i] - xs;
					z_a[i+1] <= z_a[i] + at;
				end else begin
					x_a[i+1] <= x_a[i] - ys;
					y_a[i+1] <= y_a[i] + xs;
					z_a[i+1] <= z_a[i] - at;
				end
			end
		end
	end

	assign out_valid = vld_a[N];
	assign z_out = z_a[N];
	assign side_out = side_a[N];

endmodule

// ===== rtl/scattering_angle_unit.sv =====
// channel  dir  handshake             payload
// input    in   in_valid/in_ready     point_x/y/z, normal_x/y/z
// output   out  out_valid/out_ready   angle, zero_ray
// config   in   cfg_wen               cfg_idx, cfg_data
//
// one beat per cycle sustained while out_ready holds; the pipe holds the two 31-step
// square roots, the 31-step divider and the 18-step cordic
// arst_n clears every valid bit and loads the register reset values
// a stall on out_ready freezes the whole pipe; in_ready drops with it
module scattering_angle_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  logic signed [15:0]  normal_x,
	input  logic signed [15:0]  normal_y,
	input  logic signed [15:0]  normal_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         angle,
	output logic                zero_ray
);

	// config registers
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic               deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			deg_q <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_idx)
				sau_pkg::REG_CENTER_X: cx_q <= cfg_data;
				sau_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				sau_pkg::REG_CENTER_Z: cz_q <= cfg_data;
				sau_pkg::REG_DEG_MODE: deg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipe advances together unless the output beat is stuck
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// s1: ray from sensor center to point
	logic signed [32:0] ray_s1 [0:2];
	logic signed [15:0] nrm_s1 [0:2];
	logic               deg_s1, vld_s1;

	// s2: magnitudes and signs
	logic [32:0]        mag_s2 [0:2];
	logic               neg_s2 [0:2];
	logic signed [15:0] nrm_s2 [0:2];
	logic               deg_s2, vld_s2;

	// s3: largest magnitude
	logic [32:0]        mag_s3 [0:2];
	logic               neg_s3 [0:2];
	logic signed [15:0] nrm_s3 [0:2];
	logic [32:0]        max_s3;
	logic               deg_s3, vld_s3;

	// s4: normalizing shift amounts
	logic [32:0]        mag_s4 [0:2];
	logic               neg_s4 [0:2];
	logic signed [15:0] nrm_s4 [0:2];
	logic [1:0]         rsh_s4;
	logic [4:0]         lsh_s4;
	sau_pkg::sau_flags_t fl_s4;
	logic               vld_s4;

	// s5: rescaled components, largest in [2^29, 2^30)
	logic [29:0]        scl_s5 [0:2];
	logic signed [30:0] cmp_s5 [0:2];
	logic signed [15:0] nrm_s5 [0:2];
	sau_pkg::sau_flags_t fl_s5;
	logic               vld_s5;

	// s6: products
	logic signed [46:0] prod_s6 [0:2];
	logic [59:0]        sq_s6 [0:2];
	sau_pkg::sau_flags_t fl_s6;
	logic               vld_s6;

	// s7: dot product and squared length
	logic signed [48:0] dot_s7;
	logic [61:0]        len2_s7;
	sau_pkg::sau_flags_t fl_s7;
	logic               vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	logic [5:0] lead_pos;
	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < 33; i++) begin
			if (max_s3[i]) lead_pos = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1[0] <= 33'(point_x) - 33'(cx_q);
			ray_s1[1] <= 33'(point_y) - 33'(cy_q);
			ray_s1[2] <= 33'(point_z) - 33'(cz_q);
			nrm_s1[0] <= normal_x;
			nrm_s1[1] <= normal_y;
			nrm_s1[2] <= normal_z;
			deg_s1 <= deg_q;

			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= ray_s1[i][32];
				mag_s2[i] <= ray_s1[i][32] ? (~ray_s1[i] + 33'd1) : ray_s1[i];
			end
			nrm_s2 <= nrm_s1;
			deg_s2 <= deg_s1;

			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			nrm_s3 <= nrm_s2;
			deg_s3 <= deg_s2;
			if (mag_s2[0] >= mag_s2[1] && mag_s2[0] >= mag_s2[2]) begin
				max_s3 <= mag_s2[0];
			end else if (mag_s2[1] >= mag_s2[2]) begin
				max_s3 <= mag_s2[1];
			end else begin
				max_s3 <= mag_s2[2];
			end

			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			nrm_s4 <= nrm_s3;
			fl_s4.deg <= deg_s3;
			fl_s4.zero <= (max_s3 == '0);
			rsh_s4 <= (lead_pos > 6'd29) ? 2'(lead_pos - 6'd29) : 2'd0;
			lsh_s4 <= (lead_pos < 6'd29) ? 5'(6'd29 - lead_pos) : 5'd0;

			for (int i = 0; i < 3; i++) begin
				logic [32:0] sh;
				sh = (mag_s4[i] >> rsh_s4) << lsh_s4;
				scl_s5[i] <= sh[29:0];
				cmp_s5[i] <= neg_s4[i] ? -signed'({1'b0, sh[29:0]})
					: signed'({1'b0, sh[29:0]});
			end
			nrm_s5 <= nrm_s4;
			fl_s5 <= fl_s4;

			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= 47'(cmp_s5[i]) * 47'(nrm_s5[i]);
				sq_s6[i] <= 60'(scl_s5[i]) * 60'(scl_s5[i]);
			end
			fl_s6 <= fl_s5;

			dot_s7 <= 49'(prod_s6[0]) + 49'(prod_s6[1]) + 49'(prod_s6[2]);
			len2_s7 <= 62'(sq_s6[0]) + 62'(sq_s6[1]) + 62'(sq_s6[2]);
			fl_s7 <= fl_s6;
		end
	end

	// ray length
	logic        len_vld;
	logic [30:0] len_root;
	logic [50:0] len_side;

	sau_isqrt #(
		.IN_W   (62),
		.SIDE_W (51)
	) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.radicand  (len2_s7),
		.side_in   ({dot_s7, fl_s7}),
		.out_valid (len_vld),
		.root      (len_root),
		.side_out  (len_side)
	);

	// s8: |dot| scaled for a Q1.30 quotient
	logic [63:0]         num_s8;
	logic [30:0]         len_s8;
	sau_pkg::sau_flags_t fl_s8;
	logic                vld_s8;

	// s9: quotient overflow means cosine saturates
	logic [63:0]         num_s9;
	logic [30:0]         len_s9;
	logic                ovf_s9;
	sau_pkg::sau_flags_t fl_s9;
	logic                vld_s9;

	logic signed [48:0] dot_in;
	logic [48:0]        dot_abs;
	assign dot_in = signed'(len_side[50:2]);
	assign dot_abs = dot_in[48] ? (~len_side[50:2] + 49'd1) : len_side[50:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= len_vld;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8 <= {dot_abs[47:0], 16'd0};
			len_s8 <= len_root;
			fl_s8 <= len_side[1:0];

			num_s9 <= num_s8;
			len_s9 <= len_s8;
			ovf_s9 <= (num_s8 >= {2'b00, len_s8, 31'd0});
			fl_s9 <= fl_s8;
		end
	end

	logic        div_vld;
	logic [30:0] div_q;
	logic [2:0]  div_side;

	sau_div #(
		.NUM_W  (64),
		.DEN_W  (31),
		.Q_W    (31),
		.SIDE_W (3)
	) u_cos_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s9),
		.num       (num_s9),
		.den       (len_s9),
		.side_in   ({ovf_s9, fl_s9}),
		.out_valid (div_vld),
		.quot      (div_q),
		.side_out  (div_side)
	);

	// s10 cosine, s11 its square, s12 sine squared
	logic [30:0]         cos_s10, cos_s11, cos_s12;
	logic [60:0]         sq_s11;
	logic [60:0]         sin2_s12;
	sau_pkg::sau_flags_t fl_s10, fl_s11, fl_s12;
	logic                vld_s10, vld_s11, vld_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s10 <= div_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s10 <= (div_side[2] || div_q > 31'h4000_0000) ? 31'h4000_0000 : div_q;
			fl_s10 <= div_side[1:0];

			sq_s11 <= 61'(cos_s10) * 61'(cos_s10);
			cos_s11 <= cos_s10;
			fl_s11 <= fl_s10;

			sin2_s12 <= {1'b1, 60'd0} - sq_s11;
			cos_s12 <= cos_s11;
			fl_s12 <= fl_s11;
		end
	end

	logic        sin_vld;
	logic [30:0] sin_root;
	logic [32:0] sin_side;

	sau_isqrt #(
		.IN_W   (62),
		.SIDE_W (33)
	) u_sin_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s12),
		.radicand  ({1'b0, sin2_s12}),
		.side_in   ({cos_s12, fl_s12}),
		.out_valid (sin_vld),
		.root      (sin_root),
		.side_out  (sin_side)
	);

	logic               cor_vld;
	logic signed [27:0] cor_z;
	logic [1:0]         cor_side;

	sau_cordic #(
		.XY_W   (34),
		.Z_W    (28),
		.SIDE_W (2)
	) u_atan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sin_vld),
		.x_in      (signed'({3'b000, sin_side[32:2]})),
		.y_in      (signed'({3'b000, sin_root})),
		.side_in   (sin_side[1:0]),
		.out_valid (cor_vld),
		.z_out     (cor_z),
		.side_out  (cor_side)
	);

	// s13: clamp at zero, degree product and radian rounding
	logic [47:0]         dprod_s13;
	logic [16:0]         rad_s13;
	sau_pkg::sau_flags_t fl_s13;
	logic                vld_s13;

	// s14: output register
	logic [15:0] angle_s14;
	logic        zero_s14;
	logic        vld_s14;

	logic [25:0] z_pos;
	assign z_pos = cor_z[27] ? 26'd0 : cor_z[25:0];

	logic [16:0] deg_round;
	logic [47:0] deg_sum;
	assign deg_sum = dprod_s13 + 48'h0000_8000_0000;
	assign deg_round = 17'(deg_sum >> 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s13 <= cor_vld;
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s13 <= 48'(z_pos) * 48'(sau_pkg::DEG_PER_RAD_Q16);
			rad_s13 <= 17'((27'(z_pos) + 27'd256) >> 9);
			fl_s13 <= cor_side;

			zero_s14 <= fl_s13.zero;
			if (fl_s13.deg) begin
				if (fl_s13.zero || deg_round > 17'(sau_pkg::DEG_NINETY_Q8)) begin
					angle_s14 <= sau_pkg::DEG_NINETY_Q8;
				end else begin
					angle_s14 <= deg_round[15:0];
				end
			end else begin
				if (fl_s13.zero || rad_s13 > 17'(sau_pkg::RAD_HALF_PI_Q15)) begin
					angle_s14 <= sau_pkg::RAD_HALF_PI_Q15;
				end else begin
					angle_s14 <= rad_s13[15:0];
				end
			end
		end
	end

	assign out_valid = vld_s14;
	assign angle = angle_s14;
	assign zero_ray = zero_s14;

endmodule

// ===== rtl/sau_checker.sv =====
`include "assert_macros.svh"

module sau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] angle,
	input logic        zero_ray
);

	// a held result beat stays put
	`SAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`SAU_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(angle) && $stable(zero_ray))
	// taking the output always frees the input side
	`SAU_ASSERT(a_ready_follows, out_ready |-> in_ready)
	// coincident point gives exactly a right angle
	`SAU_ASSERT(a_zero_ray, out_valid && zero_ray |-> angle == 16'd23040 || angle == 16'd51472)
	// angle never passes 51472, the right angle in radian mode
	`SAU_ASSERT(a_angle_cap, out_valid |-> angle <= 16'd51472)

endmodule

bind scattering_angle_unit sau_checker u_sau_checker (.*);
